[rtl/fdp_pkg.sv]
// ----------------------------------------------------------------------------
// fdp_pkg
// Types and constants shared by the FAT32 directory entry parser modules.
// ----------------------------------------------------------------------------
package fdp_pkg;

  // Directory entry layout.
  localparam int unsigned NAME_LEN    = 11;
  localparam int unsigned BASE_LEN    = 8;
  localparam int unsigned EXT_LEN     = 3;

  localparam logic [4:0] POS_FIRST    = 5'd0;
  localparam logic [4:0] POS_ATTR     = 5'd11;
  localparam logic [4:0] POS_CLU_HI0  = 5'd20;
  localparam logic [4:0] POS_CLU_HI1  = 5'd21;
  localparam logic [4:0] POS_CLU_LO0  = 5'd26;
  localparam logic [4:0] POS_CLU_LO1  = 5'd27;
  localparam logic [4:0] POS_SIZE0    = 5'd28;
  localparam logic [4:0] POS_SIZE1    = 5'd29;
  localparam logic [4:0] POS_SIZE2    = 5'd30;
  localparam logic [4:0] POS_LAST     = 5'd31;

  // Marker bytes.
  localparam logic [7:0] BYTE_END       = 8'h00;
  localparam logic [7:0] BYTE_DELETED   = 8'hE5;
  localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
  localparam int unsigned ATTR_DIR_BIT  = 4;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;

  // Limit after reset.
  localparam logic [15:0] MAX_ENTRIES_RESET = 16'd64;

  // Result kinds.
  typedef enum logic {
    KIND_ENTRY = 1'b0,
    KIND_END   = 1'b1
  } kind_t;

  // One classified entry handed from the front to the back.
  typedef struct packed {
    kind_t                    kind;
    logic [NAME_LEN-1:0][7:0] name;
    logic [31:0]              data_size;
    logic [31:0]              first_cluster;
    logic                     is_directory;
    logic [15:0]              entry_number;
    logic                     is_last;
  } job_t;

  // Handshake between the queue and its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/fdp_in_if.sv]
// ----------------------------------------------------------------------------
// fdp_in_if
// Byte stream channel carrying raw directory bytes.
// ----------------------------------------------------------------------------
interface fdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       dir_start;

  modport source (output valid, output data_byte, output dir_start, input ready);
  modport sink   (input valid, input data_byte, input dir_start, output ready);
endinterface

[rtl/fdp_out_if.sv]
// ----------------------------------------------------------------------------
// fdp_out_if
// Result channel carrying one parsed directory entry or an end marker.
// ----------------------------------------------------------------------------
interface fdp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [63:0] name_base;
  logic [3:0]  base_length;
  logic [23:0] name_ext;
  logic [1:0]  ext_length;
  logic [31:0] data_size;
  logic [31:0] first_cluster;
  logic        is_directory;
  logic [15:0] entry_number;
  logic        is_last;

  modport source (output valid, output result_kind, output name_base,
                  output base_length, output name_ext, output ext_length,
                  output data_size, output first_cluster, output is_directory,
                  output entry_number, output is_last, input ready);
  modport sink   (input valid, input result_kind, input name_base,
                  input base_length, input name_ext, input ext_length,
                  input data_size, input first_cluster, input is_directory,
                  input entry_number, input is_last, output ready);
endinterface

[rtl/fdp_front.sv]
// ----------------------------------------------------------------------------
// fdp_front
// Accepts directory bytes, tracks the position in each 32-byte entry,
// collects the fields and classifies the entry as reported, skipped or end.
// ----------------------------------------------------------------------------
module fdp_front
  import fdp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  fdp_in_if.sink        in_ch,
  input  queue_status_t q_status,
  output logic          push,
  output job_t          push_job
);

  logic [4:0]  pos_r, pos_nxt;
  logic        skip_r, skip_nxt;
  logic        done_r, done_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] max_r;
  logic [7:0]  name_r [NAME_LEN];
  logic [7:0]  name_nxt [NAME_LEN];
  logic [7:0]  attr_r, attr_nxt;
  logic [15:0] clu_hi_r, clu_hi_nxt;
  logic [15:0] clu_lo_r, clu_lo_nxt;
  logic [23:0] size_r, size_nxt;

  logic        accept;
  logic [4:0]  pos_eff;
  logic [15:0] count_eff;
  logic        done_eff;
  logic [7:0]  b;
  logic [16:0] count_inc;

  // The queue absorbs results, so bytes stall only when it is full.
  assign in_ch.ready = ~q_status.full;
  assign accept      = in_ch.valid & in_ch.ready;
  assign b           = in_ch.data_byte;

  // A new directory clears position, count and done before the byte is used.
  assign pos_eff   = in_ch.dir_start ? POS_FIRST : pos_r;
  assign count_eff = in_ch.dir_start ? 16'd0 : count_r;
  assign done_eff  = in_ch.dir_start ? 1'b0 : done_r;
  assign count_inc = {1'b0, count_eff} + 17'd1;

  // Byte handling and classification.
  always_comb begin
    pos_nxt    = pos_r;
    skip_nxt   = skip_r;
    done_nxt   = done_r;
    count_nxt  = count_r;
    name_nxt   = name_r;
    attr_nxt   = attr_r;
    clu_hi_nxt = clu_hi_r;
    clu_lo_nxt = clu_lo_r;
    size_nxt   = size_r;
    push       = 1'b0;
    push_job   = '0;

    if (accept) begin
      pos_nxt   = pos_eff;
      count_nxt = count_eff;
      done_nxt  = done_eff;

      if (done_eff) begin
        // Bytes after the listing ends are dropped.
      end else if (pos_eff == POS_FIRST && count_eff >= max_r) begin
        done_nxt = 1'b1;
      end else if (pos_eff == POS_FIRST && b == BYTE_END) begin
        done_nxt              = 1'b1;
        push                  = 1'b1;
        push_job.kind         = KIND_END;
        push_job.entry_number = count_eff;
        push_job.is_last      = 1'b1;
      end else begin
        if (pos_eff == POS_FIRST) begin
          skip_nxt = (b == BYTE_DELETED);
        end
        if (pos_eff < 5'(NAME_LEN)) begin
          name_nxt[pos_eff[3:0]] = b;
        end
        unique case (pos_eff)
          POS_ATTR: begin
            attr_nxt = b;
            if (b == ATTR_LONG_NAME) begin
              skip_nxt = 1'b1;
            end
          end
          POS_CLU_HI0: clu_hi_nxt[7:0]  = b;
          POS_CLU_HI1: clu_hi_nxt[15:8] = b;
          POS_CLU_LO0: clu_lo_nxt[7:0]  = b;
          POS_CLU_LO1: clu_lo_nxt[15:8] = b;
          POS_SIZE0:   size_nxt[7:0]    = b;
          POS_SIZE1:   size_nxt[15:8]   = b;
          POS_SIZE2:   size_nxt[23:16]  = b;
          default: begin
          end
        endcase

        // The last byte of a reported entry completes its result.
        if (pos_eff == POS_LAST && !skip_r) begin
          push                   = 1'b1;
          push_job.kind          = KIND_ENTRY;
          for (int j = 0; j < NAME_LEN; j++) begin
            push_job.name[j] = name_r[j];
          end
          push_job.data_size     = {b, size_r};
          push_job.first_cluster = {clu_hi_r, clu_lo_r};
          push_job.is_directory  = attr_r[ATTR_DIR_BIT];
          push_job.entry_number  = count_eff;
          push_job.is_last       = (count_inc >= {1'b0, max_r});
          count_nxt              = count_inc[15:0];
          if (count_inc >= {1'b0, max_r}) begin
            done_nxt = 1'b1;
          end
        end
        pos_nxt = pos_eff + 5'd1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_FIRST;
      skip_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= 16'd0;
      max_r   <= MAX_ENTRIES_RESET;
    end else begin
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  // Collected entry fields.
  always_ff @(posedge clk) begin
    name_r   <= name_nxt;
    attr_r   <= attr_nxt;
    clu_hi_r <= clu_hi_nxt;
    clu_lo_r <= clu_lo_nxt;
    size_r   <= size_nxt;
  end

endmodule

[rtl/fdp_queue.sv]
// ----------------------------------------------------------------------------
// fdp_queue
// Short first-in first-out queue of classified entries between the front
// and the back.
// ----------------------------------------------------------------------------
module fdp_queue
  import fdp_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          pop_job,
  output queue_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == CNT_W'(DEPTH));
  assign status.empty = (cnt_r == '0);
  assign pop_job      = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // The front must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("queue push while full");

  // The back must never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue pop while empty");

  // The fill count rises by one on a push without a pop.
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("queue fill count did not advance on push");

endmodule

[rtl/fdp_back.sv]
// ----------------------------------------------------------------------------
// fdp_back
// Takes classified entries from the queue, forms the 8.3 name fields and
// holds the result in an output register until it is transferred.
// ----------------------------------------------------------------------------
module fdp_back
  import fdp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  queue_status_t q_status,
  input  job_t          pop_job,
  output logic          pop,
  fdp_out_if.source     out_ch
);

  logic        valid_r;
  logic        kind_r;
  logic [63:0] base_r;
  logic [3:0]  base_len_r;
  logic [23:0] ext_r;
  logic [1:0]  ext_len_r;
  logic [31:0] size_r;
  logic [31:0] cluster_r;
  logic        dir_r;
  logic [15:0] number_r;
  logic        last_r;

  logic [63:0] base_c;
  logic [3:0]  base_len_c;
  logic [23:0] ext_c;
  logic [1:0]  ext_len_c;
  logic        hit_c;

  // Load a new result when the output register is free or being drained.
  assign pop = !q_status.empty && (!valid_r || out_ch.ready);

  // Base name and extension each run up to their first space, so the
  // extension is empty when it opens with a space.
  always_comb begin
    base_c     = '0;
    base_len_c = '0;
    ext_c      = '0;
    ext_len_c  = '0;
    hit_c      = 1'b0;
    for (int j = 0; j < BASE_LEN; j++) begin
      if (pop_job.name[j] == CHAR_SPACE) begin
        hit_c = 1'b1;
      end
      if (!hit_c) begin
        base_c[8*j +: 8] = pop_job.name[j];
        base_len_c       = base_len_c + 4'd1;
      end
    end
    hit_c = 1'b0;
    for (int j = 0; j < EXT_LEN; j++) begin
      if (pop_job.name[BASE_LEN + j] == CHAR_SPACE) begin
        hit_c = 1'b1;
      end
      if (!hit_c) begin
        ext_c[8*j +: 8] = pop_job.name[BASE_LEN + j];
        ext_len_c       = ext_len_c + 2'd1;
      end
    end
    // An end result carries no name at all.
    if (pop_job.kind == KIND_END) begin
      base_len_c = '0;
      ext_len_c  = '0;
    end
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r     <= pop_job.kind;
      base_r     <= base_c;
      base_len_r <= base_len_c;
      ext_r      <= ext_c;
      ext_len_r  <= ext_len_c;
      size_r     <= pop_job.data_size;
      cluster_r  <= pop_job.first_cluster;
      dir_r      <= pop_job.is_directory;
      number_r   <= pop_job.entry_number;
      last_r     <= pop_job.is_last;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.result_kind   = kind_r;
  assign out_ch.name_base     = base_r;
  assign out_ch.base_length   = base_len_r;
  assign out_ch.name_ext      = ext_r;
  assign out_ch.ext_length    = ext_len_r;
  assign out_ch.data_size     = size_r;
  assign out_ch.first_cluster = cluster_r;
  assign out_ch.is_directory  = dir_r;
  assign out_ch.entry_number  = number_r;
  assign out_ch.is_last       = last_r;

endmodule

[rtl/fat32_dir_entry_parser.sv]
// ----------------------------------------------------------------------------
// fat32_dir_entry_parser
// Parses a FAT32 directory byte stream into 8.3 directory entry results.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one raw directory byte per transfer, with dir_start set on
//   byte 0 of a new directory. Bytes form 32-byte entries. out_ch carries one
//   result per reported entry, taken at its last byte, and one end result
//   when an entry opens with a zero byte. Deleted and long-name entries give
//   no result. cfg_wr_en with cfg_wr_data sets the entry limit.
//   Throughput: one byte per cycle, sustained while the queue is not full.
//   Results: a result enters the queue when the byte that completes it is
//   transferred, then moves to the output register when that register is free or being drained.
//   Reset: position, counters and queue clear, the limit returns to 64 and
//   the output channel holds no result.
//   Stall: while out_ch is stalled the front keeps taking bytes; a queue of
//   QUEUE_DEPTH results sits between front and back, and in_ch.ready drops
//   only when that queue is full.
// ----------------------------------------------------------------------------
module fat32_dir_entry_parser
  import fdp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  fdp_in_if.sink      in_ch,
  fdp_out_if.source   out_ch
);

  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          pop_job;
  queue_status_t q_status;

  // Byte collection and classification.
  fdp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .q_status    (q_status),
    .push        (push),
    .push_job    (push_job)
  );

  // Decoupling queue.
  fdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  // Result formatting and output register.
  fdp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .pop_job  (pop_job),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
